/* rtl/core/cubic_bezier_evaluator_core_macros.svh */
// Assertion macros shared by the cubic Bezier evaluator RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef CUBIC_BEZIER_EVALUATOR_CORE_MACROS_SVH
`define CUBIC_BEZIER_EVALUATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CBE_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CBE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/cbe_pkg.sv */
// Shared types, widths and register codes for the cubic Bezier evaluator.
// No dependencies; used by every module of the core.
package cbe_pkg;

  localparam int COORD_W = 16;
  localparam int T_FRAC  = 16;
  localparam int T_W     = 17;
  localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;

  // Power-basis coefficient widths
  localparam int A_W = 19;
  localparam int B_W = 20;
  localparam int C_W = 19;

  localparam int T2_W = 2 * T_W - 1;
  localparam int T3_W = 3 * T_W - 2;
  localparam int LO_W = 24;

  localparam int AT_W   = A_W + T_W;
  localparam int BT_W   = B_W + T_W;
  localparam int CT_W   = C_W + T_W;
  localparam int AT2_W  = A_W + T2_W;
  localparam int BT2_W  = B_W + T2_W;
  localparam int AT3L_W = A_W + LO_W + 1;
  localparam int AT3H_W = A_W + T3_W - LO_W + 1;
  localparam int ACC6_W = AT_W + 4;
  localparam int VS_W   = 56;
  localparam int PS_W   = 64;

  localparam int POS_W = 32;
  localparam int VEL_W = 35;
  localparam int ACC_W = 37;

  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 2 * (POS_W + VEL_W + ACC_W);

  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  localparam logic [REG_IDX_W-1:0] REG_START_X  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_START_Y  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_X  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_Y  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_X = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_Y = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_END_X    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_END_Y    = 3'd7;

  // Pipeline stages
  localparam int NSTG    = 5;
  localparam int ST_IN   = 0;
  localparam int ST_LIN  = 1;
  localparam int ST_SQ   = 2;
  localparam int ST_CUBE = 3;
  localparam int ST_OUT  = 4;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [A_W-1:0]     a_t;
  typedef logic signed [B_W-1:0]     b_t;
  typedef logic signed [C_W-1:0]     c_t;
  typedef logic signed [ACC6_W-1:0]  acc6_t;
  typedef logic signed [VS_W-1:0]    vsum_t;
  typedef logic signed [PS_W-1:0]    psum_t;
  typedef logic signed [POS_W-1:0]   pos_t;
  typedef logic signed [VEL_W-1:0]   vel_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  // B(t) = a t^3 + b t^2 + c t + d per axis
  typedef struct packed {
    logic signed [A_W-1:0]     a;
    logic signed [B_W-1:0]     b;
    logic signed [C_W-1:0]     c;
    logic signed [COORD_W-1:0] d;
  } coef_t;

  typedef struct packed {
    logic [NSTG-1:0] adv;
  } pipe_ctl_t;

  function automatic coef_t make_coef(coord_t p0, coord_t p1, coord_t p2, coord_t p3);
    coef_t cf;
    a_t    d12;
    b_t    m;
    c_t    e;
    d12  = a_t'(p1) - a_t'(p2);
    cf.a = a_t'(p3) - a_t'(p0) + (d12 <<< 1) + d12;
    m    = b_t'(p0) - (b_t'(p1) <<< 1) + b_t'(p2);
    cf.b = (m <<< 1) + m;
    e    = c_t'(p1) - c_t'(p0);
    cf.c = (e <<< 1) + e;
    cf.d = p0;
    return cf;
  endfunction

endpackage

/* rtl/core/cbe_cfg_regs.sv */
// Control point registers behind the APB port, plus registered curve coefficients.
// Depends on cbe_pkg.
module cbe_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cbe_pkg::ADDR_W-1:0]  paddr,
  input  logic [cbe_pkg::DATA_W-1:0]  pwdata,
  output logic [cbe_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output cbe_pkg::coef_t              coef_x,
  output cbe_pkg::coef_t              coef_y
);

  cbe_pkg::coord_t                    cfg [cbe_pkg::NUM_REGS];
  logic [cbe_pkg::REG_IDX_W-1:0]      idx;
  logic                               wr;

  assign idx    = paddr[cbe_pkg::ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = {{(cbe_pkg::DATA_W - cbe_pkg::COORD_W){1'b0}}, cfg[idx]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cbe_pkg::NUM_REGS; i++) begin
        cfg[i] <= '0;
      end
    end else if (wr) begin
      cfg[idx] <= cbe_pkg::coord_t'(pwdata[cbe_pkg::COORD_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_x <= '0;
      coef_y <= '0;
    end else begin
      coef_x <= cbe_pkg::make_coef(cfg[cbe_pkg::REG_START_X], cfg[cbe_pkg::REG_FIRST_X],
                                   cfg[cbe_pkg::REG_SECOND_X], cfg[cbe_pkg::REG_END_X]);
      coef_y <= cbe_pkg::make_coef(cfg[cbe_pkg::REG_START_Y], cfg[cbe_pkg::REG_FIRST_Y],
                                   cfg[cbe_pkg::REG_SECOND_Y], cfg[cbe_pkg::REG_END_Y]);
    end
  end

endmodule

/* rtl/core/cbe_pipe_ctrl.sv */
// Valid bits and per-stage advance for the evaluator pipeline.
// Depends on cbe_pkg and the shared assertion macros.
`include "cubic_bezier_evaluator_core_macros.svh"

module cbe_pipe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  output cbe_pkg::pipe_ctl_t ctl
);

  logic [cbe_pkg::NSTG-1:0] valid;
  logic [cbe_pkg::NSTG-1:0] prev;
  logic [cbe_pkg::NSTG-1:0] adv;

  // A stage moves when it is empty or the one after it moves.
  always_comb begin
    adv[cbe_pkg::NSTG-1] = !valid[cbe_pkg::NSTG-1] || m_tready;
    for (int k = cbe_pkg::NSTG - 2; k >= 0; k--) begin
      adv[k] = !valid[k] || adv[k+1];
    end
  end

  assign prev     = {valid[cbe_pkg::NSTG-2:0], s_tvalid};
  assign s_tready = adv[cbe_pkg::ST_IN];
  assign m_tvalid = valid[cbe_pkg::NSTG-1];
  assign ctl.adv  = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int k = 0; k < cbe_pkg::NSTG; k++) begin
        if (adv[k]) begin
          valid[k] <= prev[k];
        end
      end
    end
  end

  `CBE_ASSERT_NEXT(a_accept_fills, clk, rst, s_tvalid && adv[cbe_pkg::ST_IN], valid[cbe_pkg::ST_IN], "accepted word missing from first stage")
  `CBE_ASSERT_IMPLY(a_full_stall, clk, rst, (&valid) && !m_tready, !s_tready, "word taken while pipeline full and stalled")
  `CBE_ASSERT_NEXT(a_hold_mid, clk, rst, valid[cbe_pkg::ST_SQ] && !adv[cbe_pkg::ST_SQ], valid[cbe_pkg::ST_SQ], "stalled stage lost its word")
  `CBE_ASSERT_NEXT(a_drain, clk, rst, valid[cbe_pkg::ST_CUBE] && adv[cbe_pkg::ST_OUT], m_tvalid, "word dropped before output stage")

endmodule

/* rtl/core/cbe_tpow.sv */
// Clamps t, then forms t^2 and t^3 with one multiply each, shared by both axes.
// Depends on cbe_pkg.
module cbe_tpow (
  input  logic                      clk,
  input  cbe_pkg::pipe_ctl_t        ctl,
  input  logic [cbe_pkg::T_W-1:0]   param_t,
  output logic [cbe_pkg::T_W-1:0]   t1,
  output logic [cbe_pkg::T2_W-1:0]  t2,
  output logic [cbe_pkg::T3_W-1:0]  t3
);

  logic [cbe_pkg::T_W-1:0] t1d;

  always_ff @(posedge clk) begin
    if (ctl.adv[cbe_pkg::ST_IN]) begin
      // clamp anything above one to one
      t1 <= (param_t > cbe_pkg::T_ONE) ? cbe_pkg::T_ONE : param_t;
    end
    if (ctl.adv[cbe_pkg::ST_LIN]) begin
      t2  <= t1 * t1;
      t1d <= t1;
    end
    if (ctl.adv[cbe_pkg::ST_SQ]) begin
      t3 <= t2 * t1d;
    end
  end

endmodule

/* rtl/core/cbe_axis_pipe.sv */
// Per-axis datapath: position, first and second derivative from t powers.
// Depends on cbe_pkg; fed by cbe_tpow and cbe_cfg_regs.
module cbe_axis_pipe (
  input  logic                      clk,
  input  cbe_pkg::pipe_ctl_t        ctl,
  input  cbe_pkg::coef_t            coef,
  input  logic [cbe_pkg::T_W-1:0]   t1,
  input  logic [cbe_pkg::T2_W-1:0]  t2,
  input  logic [cbe_pkg::T3_W-1:0]  t3,
  output cbe_pkg::pos_t             pos,
  output cbe_pkg::vel_t             vel,
  output cbe_pkg::acc_t             acc
);

  logic signed [cbe_pkg::T_W:0]               t1s;
  logic signed [cbe_pkg::T2_W:0]              t2s;
  logic signed [cbe_pkg::LO_W:0]              t3lo;
  logic signed [cbe_pkg::T3_W-cbe_pkg::LO_W:0] t3hi;

  logic signed [cbe_pkg::AT_W-1:0]   s1_at;
  logic signed [cbe_pkg::BT_W-1:0]   s1_bt;
  logic signed [cbe_pkg::CT_W-1:0]   s1_ct;

  logic signed [cbe_pkg::AT2_W-1:0]  s2_at2;
  logic signed [cbe_pkg::BT2_W-1:0]  s2_bt2;
  logic signed [cbe_pkg::BT_W-1:0]   s2_bt;
  logic signed [cbe_pkg::CT_W-1:0]   s2_ct;
  cbe_pkg::acc_t                     s2_acc;

  logic signed [cbe_pkg::AT3L_W-1:0] s3_at3_lo;
  logic signed [cbe_pkg::AT3H_W-1:0] s3_at3_hi;
  cbe_pkg::psum_t                    s3_part;
  cbe_pkg::vel_t                     s3_vel;
  cbe_pkg::acc_t                     s3_acc;

  cbe_pkg::acc6_t at_w;
  cbe_pkg::acc6_t at6;
  cbe_pkg::acc6_t acc_sum;
  cbe_pkg::vsum_t at2_w;
  cbe_pkg::vsum_t vsum;
  cbe_pkg::psum_t part;
  cbe_pkg::psum_t psum;

  assign t1s  = $signed({1'b0, t1});
  assign t2s  = $signed({1'b0, t2});
  assign t3lo = $signed({1'b0, t3[cbe_pkg::LO_W-1:0]});
  assign t3hi = $signed({1'b0, t3[cbe_pkg::T3_W-1:cbe_pkg::LO_W]});

  // second derivative: 6 a t + 2 b S, already at 16 fraction bits
  always_comb begin
    at_w    = cbe_pkg::acc6_t'(s1_at);
    at6     = (at_w <<< 2) + (at_w <<< 1);
    acc_sum = at6 + (cbe_pkg::acc6_t'(coef.b) <<< (cbe_pkg::T_FRAC + 1));
  end

  // first derivative: 3 a t^2 + 2 b t S + c S^2, then drop 16 fraction bits
  always_comb begin
    at2_w = cbe_pkg::vsum_t'(s2_at2);
    vsum  = at2_w + (at2_w <<< 1)
          + (cbe_pkg::vsum_t'(s2_bt) <<< (cbe_pkg::T_FRAC + 1))
          + (cbe_pkg::vsum_t'(coef.c) <<< (2 * cbe_pkg::T_FRAC));
  end

  // position terms that do not need t^3; sums wrap mod 2^64, the total fits
  always_comb begin
    part = (cbe_pkg::psum_t'(s2_bt2) <<< cbe_pkg::T_FRAC)
         + (cbe_pkg::psum_t'(s2_ct) <<< (2 * cbe_pkg::T_FRAC))
         + (cbe_pkg::psum_t'(coef.d) <<< (3 * cbe_pkg::T_FRAC));
    psum = (cbe_pkg::psum_t'(s3_at3_hi) <<< cbe_pkg::LO_W)
         + cbe_pkg::psum_t'(s3_at3_lo) + s3_part;
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[cbe_pkg::ST_LIN]) begin
      s1_at <= coef.a * t1s;
      s1_bt <= coef.b * t1s;
      s1_ct <= coef.c * t1s;
    end
    if (ctl.adv[cbe_pkg::ST_SQ]) begin
      s2_at2 <= coef.a * t2s;
      s2_bt2 <= coef.b * t2s;
      s2_bt  <= s1_bt;
      s2_ct  <= s1_ct;
      s2_acc <= cbe_pkg::acc_t'(acc_sum);
    end
    if (ctl.adv[cbe_pkg::ST_CUBE]) begin
      // a * t^3 split in two partial products
      s3_at3_lo <= coef.a * t3lo;
      s3_at3_hi <= coef.a * t3hi;
      s3_part   <= part;
      s3_vel    <= cbe_pkg::vel_t'(vsum >>> cbe_pkg::T_FRAC);
      s3_acc    <= s2_acc;
    end
    if (ctl.adv[cbe_pkg::ST_OUT]) begin
      pos <= cbe_pkg::pos_t'(psum >>> (2 * cbe_pkg::T_FRAC));
      vel <= s3_vel;
      acc <= s3_acc;
    end
  end

endmodule

/* rtl/core/cubic_bezier_evaluator_core.sv */
// Cubic Bezier evaluator: point, first and second derivative for each t.
// A word taken on s_tdata passes the in, lin, sq, cube and out stage registers before m_tvalid shows it.
// Throughput: one word per cycle; the five-stage pipeline stalls from the output back.
// Reset (rst, synchronous): empties the pipeline and sets all control points to zero.
module cubic_bezier_evaluator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [cbe_pkg::S_TDATA_W-1:0] s_tdata,   // param_t[16:0], zero pad
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [cbe_pkg::M_TDATA_W-1:0] m_tdata,   // pos_x, pos_y, vel_x, vel_y, acc_x, acc_y
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cbe_pkg::ADDR_W-1:0]    paddr,
  input  logic [cbe_pkg::DATA_W-1:0]    pwdata,
  output logic [cbe_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  cbe_pkg::pipe_ctl_t               ctl;
  cbe_pkg::coef_t                   coef_x;
  cbe_pkg::coef_t                   coef_y;
  logic [cbe_pkg::T_W-1:0]          t1;
  logic [cbe_pkg::T2_W-1:0]         t2;
  logic [cbe_pkg::T3_W-1:0]         t3;
  cbe_pkg::pos_t                    pos_x, pos_y;
  cbe_pkg::vel_t                    vel_x, vel_y;
  cbe_pkg::acc_t                    acc_x, acc_y;

  cbe_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef_x  (coef_x),
    .coef_y  (coef_y)
  );

  cbe_pipe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .ctl      (ctl)
  );

  cbe_tpow u_tpow (
    .clk     (clk),
    .ctl     (ctl),
    .param_t (s_tdata[cbe_pkg::T_W-1:0]),
    .t1      (t1),
    .t2      (t2),
    .t3      (t3)
  );

  cbe_axis_pipe u_axis_x (
    .clk  (clk),
    .ctl  (ctl),
    .coef (coef_x),
    .t1   (t1),
    .t2   (t2),
    .t3   (t3),
    .pos  (pos_x),
    .vel  (vel_x),
    .acc  (acc_x)
  );

  cbe_axis_pipe u_axis_y (
    .clk  (clk),
    .ctl  (ctl),
    .coef (coef_y),
    .t1   (t1),
    .t2   (t2),
    .t3   (t3),
    .pos  (pos_y),
    .vel  (vel_y),
    .acc  (acc_y)
  );

  assign m_tdata = {acc_y, acc_x, vel_y, vel_x, pos_y, pos_x};

endmodule

/* test/tb_cubic_bezier_evaluator_core.sv */
// Self-checking testbench for the cubic Bezier evaluator core.
// Depends on cbe_pkg and cubic_bezier_evaluator_core; drives the parameter stream and the
// APB register port and checks every result word against a local exact-integer predictor.
`timescale 1ns / 1ps

module tb_cubic_bezier_evaluator_core;
  import cbe_pkg::*;

  localparam int LATENCY    = 4;
  localparam int STALL_MAX  = 2000;
  localparam int RAND_SETS  = 8;
  localparam int RAND_ITEMS = 190;
  localparam int MAX_SHOWN  = 10;

  typedef logic signed [79:0] wide_t;
  typedef logic [M_TDATA_W-1:0] point_word_t;

  // Result word layout, lowest field first
  localparam int FLD_LO [6] = '{0, 32, 64, 99, 134, 171};
  localparam int FLD_W  [6] = '{POS_W, POS_W, VEL_W, VEL_W, ACC_W, ACC_W};
  localparam string FLD_NAME [6] = '{"pos_x", "pos_y", "vel_x", "vel_y", "acc_x", "acc_y"};

  localparam coord_t CMIN = 16'sh8000;
  localparam coord_t CMAX = 16'sh7FFF;

  localparam point_word_t ZERO_PT = '0;
  // x held at the top coordinate, y at the bottom: a single point, no motion
  localparam point_word_t FLAT_PT = {37'd0, 37'd0, 35'd0, 35'd0, 32'h8000_0000, 32'h7FFF_0000};

  typedef struct packed {
    logic [1:0]    setting;
    logic [T_W-1:0] t;
    logic          typed;
    point_word_t   point;
  } dir_row_t;

  localparam int DIR_N = 20;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{2'd0, 17'd0,      1'b1, ZERO_PT},
    '{2'd0, 17'd1,      1'b1, ZERO_PT},
    '{2'd0, 17'd32768,  1'b1, ZERO_PT},
    '{2'd0, 17'd65535,  1'b1, ZERO_PT},
    '{2'd0, 17'd65536,  1'b1, ZERO_PT},
    '{2'd0, 17'd65537,  1'b1, ZERO_PT},
    '{2'd0, 17'd131071, 1'b1, ZERO_PT},
    '{2'd1, 17'd0,      1'b1, FLAT_PT},
    '{2'd1, 17'd65536,  1'b1, FLAT_PT},
    '{2'd1, 17'd131071, 1'b1, FLAT_PT},
    '{2'd1, 17'd43690,  1'b1, FLAT_PT},
    '{2'd2, 17'd0,      1'b0, ZERO_PT},
    '{2'd2, 17'd1,      1'b0, ZERO_PT},
    '{2'd2, 17'd21845,  1'b0, ZERO_PT},
    '{2'd2, 17'd32768,  1'b0, ZERO_PT},
    '{2'd2, 17'd65535,  1'b0, ZERO_PT},
    '{2'd2, 17'd65536,  1'b0, ZERO_PT},
    '{2'd2, 17'd65537,  1'b0, ZERO_PT},
    '{2'd2, 17'd131071, 1'b0, ZERO_PT},
    '{2'd2, 17'd98304,  1'b0, ZERO_PT}
  };

  // Control point sets for the directed rows, register order start_x, start_y, ...
  localparam coord_t DIR_CFG [3][NUM_REGS] = '{
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN},
    '{CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN}
  };

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;   // param_t[16:0], zero pad
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;   // pos_x, pos_y, vel_x, vel_y, acc_x, acc_y
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  cubic_bezier_evaluator_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  coord_t      ctrl_points [NUM_REGS];
  point_word_t expected_points [$];
  int          src_idle_pct;
  int          sink_stall_pct;
  int          mismatches;
  int          words_sent;
  int          words_checked;
  int          settings_used;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit chance(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic void axis_terms(input coord_t p0, input coord_t p1, input coord_t p2,
                                     input coord_t p3, input wide_t tw, input wide_t uw,
                                     output pos_t pos, output vel_t vel, output acc_t acc);
    wide_t w0, w1, w2, w3, s;
    w0 = wide_t'(p0);
    w1 = wide_t'(p1);
    w2 = wide_t'(p2);
    w3 = wide_t'(p3);
    s = w0 * uw * uw * uw + 3 * w1 * tw * uw * uw + 3 * w2 * tw * tw * uw + w3 * tw * tw * tw;
    s = s >>> (3 * T_FRAC - 16);
    pos = s[POS_W-1:0];
    s = (w1 - w0) * uw * uw + 2 * (w2 - w1) * uw * tw + (w3 - w2) * tw * tw;
    s = (3 * s) >>> (2 * T_FRAC - 16);
    vel = s[VEL_W-1:0];
    s = (w2 - 2 * w1 + w0) * uw + (w3 - 2 * w2 + w1) * tw;
    s = 6 * s;
    acc = s[ACC_W-1:0];
  endfunction

  function automatic point_word_t bezier_point(input logic [T_W-1:0] t_in);
    logic [T_W-1:0] t;
    wide_t tw, uw;
    pos_t px, py;
    vel_t vx, vy;
    acc_t ax, ay;
    // t above one clamps to one
    t = (t_in > T_ONE) ? T_ONE : t_in;
    tw = '0;
    uw = '0;
    tw[T_W-1:0] = t;
    uw[T_W-1:0] = T_ONE - t;
    axis_terms(ctrl_points[REG_START_X], ctrl_points[REG_FIRST_X], ctrl_points[REG_SECOND_X],
               ctrl_points[REG_END_X], tw, uw, px, vx, ax);
    axis_terms(ctrl_points[REG_START_Y], ctrl_points[REG_FIRST_Y], ctrl_points[REG_SECOND_Y],
               ctrl_points[REG_END_Y], tw, uw, py, vy, ay);
    return {ay, ax, vy, vx, py, px};
  endfunction

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= MAX_SHOWN) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  task automatic check_point(input point_word_t got);
    point_word_t want, mask, w_f, g_f;
    if (expected_points.size() == 0) begin
      report($sformatf("result word with nothing outstanding: %h", got));
    end else begin
      want = expected_points.pop_front();
      for (int f = 0; f < 6; f++) begin
        mask = (point_word_t'(1) << FLD_W[f]) - 1;
        w_f = (want >> FLD_LO[f]) & mask;
        g_f = (got >> FLD_LO[f]) & mask;
        if (w_f !== g_f) begin
          report($sformatf("word %0d %s expected %h got %h", words_checked, FLD_NAME[f],
                           w_f, g_f));
        end
      end
    end
    words_checked++;
  endtask

  // Result side: stall at negedge, check at posedge
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= !chance(sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      check_point(m_tdata);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_MAX) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[%0t] no handshake for %0d cycles", $realtime, STALL_MAX);
    $display("simulation failed");
    $finish;
  end

  // Called at a negedge, returns at a negedge
  task automatic send_param(input logic [T_W-1:0] t, input logic typed, input point_word_t pt);
    while (chance(src_idle_pct)) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_TDATA_W'(t);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_points.push_back(typed ? pt : bezier_point(t));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(negedge clk);
  endtask

  // Called at a negedge; drops psel after the access and returns at a later negedge with the bus idle
  task automatic reg_write(input int idx, input coord_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << 2;
    // upper bits must be ignored
    pwdata  <= {16'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    ctrl_points[idx] = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_points(input coord_t pts [NUM_REGS]);
    drain();
    repeat (LATENCY + 4) @(negedge clk);
    for (int i = REG_START_X; i <= REG_END_Y; i++) begin
      reg_write(i, pts[i]);
    end
    settings_used++;
  endtask

  initial begin
    coord_t pts [NUM_REGS];
    int cur_setting;
    int pause_at;
    logic [T_W-1:0] t;

    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    mismatches     = 0;
    words_sent     = 0;
    words_checked  = 0;
    settings_used  = 1;
    foreach (ctrl_points[i]) ctrl_points[i] = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed rows, first setting is the reset state
    cur_setting = 0;
    for (int r = 0; r < DIR_N; r++) begin
      if (DIR_ROWS[r].setting != cur_setting) begin
        cur_setting = DIR_ROWS[r].setting;
        load_points(DIR_CFG[cur_setting]);
      end
      send_param(DIR_ROWS[r].t, DIR_ROWS[r].typed, DIR_ROWS[r].point);
    end

    // Random sets: cycle through the idling modes
    for (int ph = 0; ph < RAND_SETS; ph++) begin
      foreach (pts[i]) begin
        case (ph)
          0: pts[i] = CMIN;
          1: pts[i] = CMAX;
          default: begin
            case ($urandom_range(3))
              0: pts[i] = CMIN;
              1: pts[i] = CMAX;
              default: pts[i] = coord_t'($urandom);
            endcase
          end
        endcase
      end
      load_points(pts);
      src_idle_pct   = (ph % 4 == 1) ? 58 : (ph % 4 == 3) ? 25 : 0;
      sink_stall_pct = (ph % 4 == 2) ? 58 : (ph % 4 == 3) ? 25 : 0;
      pause_at = $urandom_range(RAND_ITEMS - 20, 20);
      for (int n = 0; n < RAND_ITEMS; n++) begin
        if (n == pause_at) begin
          drain();
        end
        case ($urandom_range(9))
          0: t = T_W'($urandom_range(15));
          1: t = T_ONE - T_W'($urandom_range(15));
          2: t = T_ONE + T_W'($urandom_range(65535));
          default: t = T_W'($urandom_range(65536));
        endcase
        send_param(t, 1'b0, ZERO_PT);
      end
    end

    drain();
    repeat (LATENCY + 8) @(posedge clk);
    if (expected_points.size() != 0) begin
      report($sformatf("%0d result words never arrived", expected_points.size()));
    end
    $display("covered %0d parameter words under %0d control point sets, %0d results checked",
             words_sent, settings_used, words_checked);
    $display("t spans zero, one, clamped values above one; idling on both sides; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
